@@ rtl/core/ede_pkg.sv @@
// Shared constants and types for the edit distance engine.
`timescale 1ns / 1ps

package ede_pkg;

    localparam int unsigned MAX_LEN_DEF = 64;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned DIST_W      = 7;
    localparam int unsigned FUNC_W      = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_REF    = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_FINISH = 2'd3
    } t_func;

endpackage

@@ rtl/core/ede_cell.sv @@
// Shared cost cell: diagonal on match, else minimum of three neighbors plus one.
`timescale 1ns / 1ps

module ede_cell
    import ede_pkg::*;
#(
    parameter int unsigned COST_W = 7
) (
    input  logic              i_match,
    input  logic [COST_W-1:0] i_corner,
    input  logic [COST_W-1:0] i_upper,
    input  logic [COST_W-1:0] i_left,
    output logic [COST_W-1:0] o_cost
);

    logic [COST_W-1:0] best_uc;
    logic [COST_W-1:0] best;

    always_comb begin
        best_uc = (i_upper < i_corner) ? i_upper : i_corner;
        best    = (i_left < best_uc) ? i_left : best_uc;
        if (i_match) begin
            o_cost = i_corner;
        end else begin
            o_cost = best + COST_W'(1);
        end
    end

endmodule

@@ rtl/core/edit_distance_engine_core.sv @@
// Top level of the edit distance engine: sequencer, reference and cost-row memories.
`timescale 1ns / 1ps

// Levenshtein edit distance between a stored reference and a streamed query.
// Input channel (i_in_valid / o_in_ready) carries i_func and i_char_code:
//   clear, append a reference byte, process a query byte, or finish.
// Output channel (o_out_valid / i_out_ready) carries o_distance and
//   o_overflow, one result per finish item.
// Per input item:
//   clear, append: done on acceptance.
//   query byte: one cost cell is updated per cycle by the shared cell
//     unit, which reads the cost-row memory and the reference memory
//     through one port each.
//   finish: the last cost is read, then goes to the output register when free.
// The block takes no item while a query sweep or a finish is in progress.
// A finished result sits in the output register; while the receiver stalls,
// items other than finish keep being taken, and a finish waits for the
// register to drain. Reset empties both strings and the output register and
// needs no clearing pass: the cost row reads as its start values whenever
// no query byte has been processed since the last restart.
module edit_distance_engine_core
    import ede_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [CHAR_W-1:0] i_char_code,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DIST_W-1:0] o_distance,
    output logic              o_overflow
);

    localparam int unsigned LW = $clog2(MAX_LEN + 1);
    localparam int unsigned AW = $clog2(MAX_LEN);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [LW-1:0]     r_ref_len, n_ref_len;
    logic [LW-1:0]     r_q_len, n_q_len;
    logic              r_ovf, n_ovf;
    logic [LW-1:0]     r_j, n_j;
    logic [LW-1:0]     r_left, n_left;
    logic [LW-1:0]     r_corner, n_corner;
    logic              r_fresh, n_fresh;
    logic [CHAR_W-1:0] r_qbyte, n_qbyte;
    logic              r_out_valid, n_out_valid;
    logic [DIST_W-1:0] r_distance, n_distance;
    logic              r_out_ovf, n_out_ovf;

    // memories
    logic [CHAR_W-1:0] ref_mem [MAX_LEN];
    logic [LW-1:0]     row_mem [MAX_LEN+1];
    logic [CHAR_W-1:0] r_ref_rd;
    logic [LW-1:0]     r_row_rd;

    logic              ref_we, ref_re, row_we, row_re;
    logic [AW-1:0]     ref_waddr, ref_raddr;
    logic [LW-1:0]     row_waddr, row_raddr;
    logic [CHAR_W-1:0] ref_wdata;
    logic [LW-1:0]     row_wdata;

    logic              accept;
    t_func             func;
    logic [LW-1:0]     upper;
    logic [LW-1:0]     cell_cost;
    logic [LW-1:0]     fin_cost;
    logic [LW+DIST_W-1:0] fin_wide;
    logic              out_free;

    assign func       = t_func'(i_func);
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // before the first query byte after a restart, entry k holds k
    assign upper    = r_fresh ? (r_j + LW'(1)) : r_row_rd;
    assign fin_cost = (r_q_len == '0) ? r_ref_len : r_row_rd;
    assign fin_wide = {{DIST_W{1'b0}}, fin_cost};

    ede_cell #(
        .COST_W (LW)
    ) u_cell (
        .i_match  (r_ref_rd == r_qbyte),
        .i_corner (r_corner),
        .i_upper  (upper),
        .i_left   (r_left),
        .o_cost   (cell_cost)
    );

    always_comb begin
        n_state     = r_state;
        n_ref_len   = r_ref_len;
        n_q_len     = r_q_len;
        n_ovf       = r_ovf;
        n_j         = r_j;
        n_left      = r_left;
        n_corner    = r_corner;
        n_fresh     = r_fresh;
        n_qbyte     = r_qbyte;
        n_out_valid = r_out_valid;
        n_distance  = r_distance;
        n_out_ovf   = r_out_ovf;

        ref_we    = 1'b0;
        ref_waddr = r_ref_len[AW-1:0];
        ref_wdata = i_char_code;
        ref_re    = 1'b0;
        ref_raddr = '0;
        row_we    = 1'b0;
        row_waddr = '0;
        row_wdata = r_q_len + LW'(1);
        row_re    = 1'b0;
        row_raddr = LW'(1);

        // drop the held result once transferred
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (func)
                        FUNC_CLEAR: begin
                            n_ref_len = '0;
                            n_q_len   = '0;
                            n_ovf     = 1'b0;
                        end
                        FUNC_REF: begin
                            if (r_ref_len < LW'(MAX_LEN)) begin
                                ref_we    = 1'b1;
                                n_ref_len = r_ref_len + LW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                            n_q_len = '0;
                        end
                        FUNC_QUERY: begin
                            if (r_q_len < LW'(MAX_LEN)) begin
                                row_we    = 1'b1;
                                ref_re    = 1'b1;
                                row_re    = 1'b1;
                                n_left    = r_q_len + LW'(1);
                                n_corner  = r_q_len;
                                n_fresh   = (r_q_len == '0);
                                n_qbyte   = i_char_code;
                                n_j       = '0;
                                if (r_ref_len == '0) begin
                                    n_q_len = r_q_len + LW'(1);
                                end else begin
                                    n_state = S_SWEEP;
                                end
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        FUNC_FINISH: begin
                            row_re    = 1'b1;
                            row_raddr = r_ref_len;
                            n_state   = S_FIN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                row_we    = 1'b1;
                row_waddr = r_j + LW'(1);
                row_wdata = cell_cost;
                n_left    = cell_cost;
                n_corner  = upper;
                if (r_j == r_ref_len - LW'(1)) begin
                    n_q_len = r_q_len + LW'(1);
                    n_state = S_IDLE;
                end else begin
                    n_j       = r_j + LW'(1);
                    ref_re    = 1'b1;
                    ref_raddr = AW'(r_j + LW'(1));
                    row_re    = 1'b1;
                    row_raddr = r_j + LW'(2);
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_distance  = fin_wide[DIST_W-1:0];
                    n_out_ovf   = r_ovf;
                    n_q_len     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ref_len   <= '0;
            r_q_len     <= '0;
            r_ovf       <= 1'b0;
            r_j         <= '0;
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ref_len   <= n_ref_len;
            r_q_len     <= n_q_len;
            r_ovf       <= n_ovf;
            r_j         <= n_j;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
        r_left     <= n_left;
        r_corner   <= n_corner;
        r_qbyte    <= n_qbyte;
        r_distance <= n_distance;
        r_out_ovf  <= n_out_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            ref_mem[ref_waddr] <= ref_wdata;
        end
        if (ref_re) begin
            r_ref_rd <= ref_mem[ref_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (row_re) begin
            r_row_rd <= row_mem[row_raddr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_overflow  = r_out_ovf;

endmodule
